### rtl/rrcf_pkg.sv
// Shared types, register codes and arithmetic helpers for the rounded
// rectangle coverage fill block. No dependencies.
package rrcf_pkg;

    localparam logic [12:0] MAX_DIM = 13'd4096;
    localparam int          NSTAGE  = 10;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RADIUS = 3'd2;
    localparam logic [2:0] REG_MASK   = 3'd3;
    localparam logic [2:0] REG_COLOR  = 3'd4;
    localparam logic [2:0] REG_GALPHA = 3'd5;
    localparam logic [2:0] REG_INVERT = 3'd6;

    typedef struct packed {
        logic [12:0] w_sat;
        logic [12:0] h_sat;
        logic [11:0] rad_eff;
        logic [28:0] r2;
        logic [7:0]  ca;
        logic [3:0]  corner_mask;
        logic [23:0] fill_rgb;
        logic        invert;
    } rrcf_cfg_t;

    // x / 255 for x up to 65279
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
        return t[15:8];
    endfunction

    // hits * 255 / 16
    function automatic logic [7:0] cov_lut(input logic [4:0] hits);
        logic [11:0] p;
        p = {hits, 7'b0} + {1'b0, hits, 6'b0} + {2'b0, hits, 5'b0} + {3'b0, hits, 4'b0}
            + {4'b0, hits, 3'b0} + {5'b0, hits, 2'b0} + {6'b0, hits, 1'b0} + {7'b0, hits};
        return p[11:4];
    endfunction

    // d + n / 255, division truncating toward zero, modulo 256
    function automatic logic [7:0] blend_chan(input logic signed [17:0] n,
                                              input logic [7:0] d);
        logic [17:0] neg;
        logic [7:0]  q;
        neg = 18'(-n);
        if (n[17])
        begin
            q = 8'd0 - div255(neg[15:0]);
        end
        else
        begin
            q = div255(n[15:0]);
        end
        return d + q;
    endfunction

endpackage

### rtl/rrcf_regs.sv
// APB-style register file for the coverage fill block, plus the
// registered values derived from it (saturated sizes, radius, alpha).
// Depends on rrcf_pkg.
module rrcf_regs
    import rrcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output rrcf_cfg_t   cfg
);

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [12:0] radius_reg;
    logic [3:0]  mask_reg;
    logic [31:0] color_reg;
    logic [7:0]  galpha_reg;
    logic        invert_reg;

    logic [12:0] wsat_reg, wsat_next;
    logic [12:0] hsat_reg, hsat_next;
    logic [11:0] rad_reg, rad_next;
    logic [15:0] caprod_reg, caprod_next;
    logic [7:0]  ca_reg, ca_next;
    logic [28:0] r2_reg, r2_next;

    logic [2:0]  idx;
    logic        wr;
    logic [12:0] rsat;
    logic [12:0] rmin1;
    logic [23:0] rsq;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
            radius_reg <= 13'd0;
            mask_reg   <= 4'hF;
            color_reg  <= 32'd0;
            galpha_reg <= 8'hFF;
            invert_reg <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                REG_WIDTH:  width_reg  <= pwdata[12:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                REG_RADIUS: radius_reg <= pwdata[12:0];
                REG_MASK:   mask_reg   <= pwdata[3:0];
                REG_COLOR:  color_reg  <= pwdata;
                REG_GALPHA: galpha_reg <= pwdata[7:0];
                REG_INVERT: invert_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WIDTH:  prdata = {19'd0, width_reg};
            REG_HEIGHT: prdata = {19'd0, height_reg};
            REG_RADIUS: prdata = {19'd0, radius_reg};
            REG_MASK:   prdata = {28'd0, mask_reg};
            REG_COLOR:  prdata = color_reg;
            REG_GALPHA: prdata = {24'd0, galpha_reg};
            REG_INVERT: prdata = {31'd0, invert_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // radius clamps to min(radius, w/2, h/2)
    always_comb
    begin
        wsat_next   = (width_reg  > MAX_DIM) ? MAX_DIM : width_reg;
        hsat_next   = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
        rsat        = (radius_reg > MAX_DIM) ? MAX_DIM : radius_reg;
        rmin1       = (rsat > (wsat_next >> 1)) ? (wsat_next >> 1) : rsat;
        rmin1       = (rmin1 > (hsat_next >> 1)) ? (hsat_next >> 1) : rmin1;
        rad_next    = rmin1[11:0];
        caprod_next = color_reg[31:24] * galpha_reg + 16'd127;
        ca_next     = div255(caprod_reg);
        rsq         = rad_reg * rad_reg;
        r2_next     = {rsq[22:0], 6'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsat_reg   <= 13'd1;
            hsat_reg   <= 13'd1;
            rad_reg    <= 12'd0;
            caprod_reg <= 16'd127;
            ca_reg     <= 8'd0;
            r2_reg     <= 29'd0;
        end
        else
        begin
            wsat_reg   <= wsat_next;
            hsat_reg   <= hsat_next;
            rad_reg    <= rad_next;
            caprod_reg <= caprod_next;
            ca_reg     <= ca_next;
            r2_reg     <= r2_next;
        end
    end

    always_comb
    begin
        cfg.w_sat       = wsat_reg;
        cfg.h_sat       = hsat_reg;
        cfg.rad_eff     = rad_reg;
        cfg.r2          = r2_reg;
        cfg.ca          = ca_reg;
        cfg.corner_mask = mask_reg;
        cfg.fill_rgb    = color_reg[23:0];
        cfg.invert      = invert_reg;
    end

endmodule

### rtl/rounded_rect_coverage_fill.sv
// Top level of the rounded rectangle coverage fill: ten-stage pixel
// pipeline (coverage by 4x4 supersampling, alpha weighting, blend).
// Depends on rrcf_pkg and rrcf_regs.
//
// Channel   Dir  Signals                          Payload
// s_*       in   s_tvalid s_tready s_tdata[55:0]  rel_x, rel_y, dest_pixel
// m_*       out  m_tvalid m_tready m_tdata m_tuser new_pixel, write_enable
// apb       in   psel penable pwrite paddr pwdata  registers at 4*index
//
// One pixel per clock unless m_tready stalls the output.
// Each stage has its own valid bit and loads when it is empty or drains,
// so bubbles close up under an output stall.
// Derived values are registered; r2 follows rad_reg and ca follows caprod_reg.
// Reset clears all valid bits and loads the register defaults.
module rounded_rect_coverage_fill
    import rrcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // rel_x[11:0], rel_y[23:12], dest_pixel[55:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // new_pixel[31:0]
    output logic        m_tuser,   // write_enable
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rrcf_cfg_t cfg;

    rrcf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [NSTAGE-1:0] v_reg, v_next;
    logic [NSTAGE-1:0] rdy;

    logic [31:0]        dst_reg [0:8];
    logic               skip_reg [1:8];
    logic               corner_reg [1:4];
    logic [11:0]        px0_reg, py0_reg;
    logic signed [11:0] ex1_reg, ey1_reg;
    logic signed [14:0] bx2_reg, by2_reg;
    logic [27:0]        sqx2_reg, sqy2_reg;
    logic [27:0]        dx2_reg [0:3];
    logic [27:0]        dy2_reg [0:3];
    logic [15:0]        hit4_reg;
    logic [7:0]         cov5_reg;
    logic [15:0]        aprod6_reg;
    logic [7:0]         a7_reg;
    logic               full_reg [7:8];
    logic signed [17:0] n8_reg [0:2];
    logic [31:0]        pix_reg;
    logic               we_reg;

    // stage 1 logic
    logic [12:0] px13, py13, rad13, wmr, hmr, exl, exr, eyl, eyr;
    logic        xl, xr, yl, yr, outside1, corner1;
    logic [1:0]  cidx;
    // stage 2 logic
    logic signed [14:0] bx, by;
    logic signed [29:0] sqx, sqy;
    // stage 3 logic
    logic [29:0] bxe, bye;
    logic [27:0] dx2_next [0:3];
    logic [27:0] dy2_next [0:3];
    // stage 4 logic
    logic [15:0] hit_next;
    // stage 5 logic
    logic [2:0]  nib [0:3];
    logic [4:0]  hits;
    logic [7:0]  cov_next;
    // stage 7 logic
    logic [7:0]  a_next;
    // stage 8 logic
    logic signed [17:0] n_next [0:2];
    // stage 9 logic
    logic [31:0] pix_next;

    always_comb
    begin
        rdy[NSTAGE-1] = ~v_reg[NSTAGE-1] | m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            rdy[k] = ~v_reg[k] | rdy[k+1];
        end
        v_next[0] = rdy[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[NSTAGE-1];
    assign m_tdata  = pix_reg;
    assign m_tuser  = we_reg;

    always_comb
    begin
        px13     = {1'b0, px0_reg};
        py13     = {1'b0, py0_reg};
        rad13    = {1'b0, cfg.rad_eff};
        wmr      = cfg.w_sat - rad13;
        hmr      = cfg.h_sat - rad13;
        outside1 = (px13 >= cfg.w_sat) || (py13 >= cfg.h_sat);
        xl       = px13 < rad13;
        xr       = px13 >= wmr;
        yl       = py13 < rad13;
        yr       = py13 >= hmr;
        exl      = px13 - rad13;
        exr      = px13 - wmr;
        eyl      = py13 - rad13;
        eyr      = py13 - hmr;
        cidx     = {~yl, ~xl};
        corner1  = (cfg.rad_eff != 12'd0) && (xl || xr) && (yl || yr)
                   && cfg.corner_mask[cidx];
    end

    always_comb
    begin
        bx  = {ex1_reg, 3'b001};
        by  = {ey1_reg, 3'b001};
        sqx = bx * bx;
        sqy = by * by;
    end

    // (b + 2i)^2 = b^2 + 4ib + 4i^2
    always_comb
    begin
        bxe = {{15{bx2_reg[14]}}, bx2_reg};
        bye = {{15{by2_reg[14]}}, by2_reg};
        for (int i = 0; i < 4; i++)
        begin
            dx2_next[i] = 28'({2'b0, sqx2_reg} + bxe * 30'(4 * i) + 30'(4 * i * i));
            dy2_next[i] = 28'({2'b0, sqy2_reg} + bye * 30'(4 * i) + 30'(4 * i * i));
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hit_next[j*4+i] = ({1'b0, dx2_reg[i]} + {1'b0, dy2_reg[j]}) <= cfg.r2;
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            nib[g] = {2'b0, hit4_reg[g*4]} + {2'b0, hit4_reg[g*4+1]}
                     + {2'b0, hit4_reg[g*4+2]} + {2'b0, hit4_reg[g*4+3]};
        end
        hits     = {2'b0, nib[0]} + {2'b0, nib[1]} + {2'b0, nib[2]} + {2'b0, nib[3]};
        cov_next = corner_reg[4] ? cov_lut(hits) : 8'hFF;
        if (cfg.invert)
        begin
            cov_next = ~cov_next;
        end
    end

    assign a_next = div255(aprod6_reg);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            n_next[c] = ($signed({1'b0, cfg.fill_rgb[c*8 +: 8]})
                         - $signed({1'b0, dst_reg[7][c*8 +: 8]}))
                        * $signed({1'b0, a7_reg}) + 18'sd127;
        end
    end

    always_comb
    begin
        if (skip_reg[8])
        begin
            pix_next = dst_reg[8];
        end
        else if (full_reg[8])
        begin
            pix_next = {8'hFF, cfg.fill_rgb};
        end
        else
        begin
            pix_next = {8'hFF, blend_chan(n8_reg[2], dst_reg[8][23:16]),
                        blend_chan(n8_reg[1], dst_reg[8][15:8]),
                        blend_chan(n8_reg[0], dst_reg[8][7:0])};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            px0_reg    <= s_tdata[11:0];
            py0_reg    <= s_tdata[23:12];
            dst_reg[0] <= s_tdata[55:24];
        end
        for (int k = 1; k < 9; k++)
        begin
            if (rdy[k])
            begin
                dst_reg[k] <= dst_reg[k-1];
            end
        end
        if (rdy[1])
        begin
            skip_reg[1]   <= outside1;
            corner_reg[1] <= corner1;
            ex1_reg       <= xl ? exl[11:0] : exr[11:0];
            ey1_reg       <= yl ? eyl[11:0] : eyr[11:0];
        end
        if (rdy[2])
        begin
            skip_reg[2]   <= skip_reg[1];
            corner_reg[2] <= corner_reg[1];
            bx2_reg       <= bx;
            by2_reg       <= by;
            sqx2_reg      <= sqx[27:0];
            sqy2_reg      <= sqy[27:0];
        end
        if (rdy[3])
        begin
            skip_reg[3]   <= skip_reg[2];
            corner_reg[3] <= corner_reg[2];
            for (int i = 0; i < 4; i++)
            begin
                dx2_reg[i] <= dx2_next[i];
                dy2_reg[i] <= dy2_next[i];
            end
        end
        if (rdy[4])
        begin
            skip_reg[4]   <= skip_reg[3];
            corner_reg[4] <= corner_reg[3];
            hit4_reg      <= hit_next;
        end
        if (rdy[5])
        begin
            skip_reg[5] <= skip_reg[4] || (cov_next == 8'd0) || (cfg.ca == 8'd0);
            cov5_reg    <= cov_next;
        end
        if (rdy[6])
        begin
            skip_reg[6] <= skip_reg[5];
            aprod6_reg  <= cfg.ca * cov5_reg;
        end
        if (rdy[7])
        begin
            skip_reg[7] <= skip_reg[6] || (a_next == 8'd0);
            full_reg[7] <= a_next == 8'hFF;
            a7_reg      <= a_next;
        end
        if (rdy[8])
        begin
            skip_reg[8] <= skip_reg[7];
            full_reg[8] <= full_reg[7];
            for (int c = 0; c < 3; c++)
            begin
                n8_reg[c] <= n_next[c];
            end
        end
        if (rdy[9])
        begin
            pix_reg <= pix_next;
            we_reg  <= ~skip_reg[8];
        end
    end

    a_written_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[31:24] == 8'hFF)
        else $error("written pixel not opaque");

    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&v_reg))
        else $error("input stalled with a bubble in the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[5] && !rdy[5] |=> v_reg[5] && $stable(cov5_reg) && $stable(dst_reg[5]))
        else $error("stalled stage lost its item");

    a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (cfg.ca == 8'd0) |-> !m_tuser)
        else $error("write with zero fill alpha");

endmodule
